// ----- src/tlac_pkg.sv -----
`default_nettype none

package tlac_pkg;

    localparam int LAYERS      = 3;
    localparam int ATLAS_TILES = 64;
    localparam int TILE_SIZE   = 32;

    localparam int TILE_AW     = $clog2(ATLAS_TILES);
    localparam int PIX_AW      = 2 * $clog2(TILE_SIZE);
    localparam int ADDR_W      = TILE_AW + PIX_AW;
    localparam int STORE_DEPTH = ATLAS_TILES * TILE_SIZE * TILE_SIZE;

    // B,G,R,A, one height byte per layer, bush byte
    localparam int WORD_BYTES  = LAYERS + 5;
    localparam int WORD_W      = 8 * WORD_BYTES;
    localparam int HEIGHT_BYTE = 4;
    localparam int BUSH_BYTE   = 4 + LAYERS;

    localparam logic [10:0] MAIN_BASE   = 11'd384;
    localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;

    localparam logic REG_AUTOTILE   = 1'b0;
    localparam logic REG_AUTOHEIGHT = 1'b1;

    typedef enum logic {
        OP_DRAW    = 1'b0,
        OP_REFRESH = 1'b1
    } op_t;

    typedef logic [WORD_BYTES-1:0][7:0] word_t;

    typedef struct packed {
        op_t               op;
        logic [1:0]        layer;
        logic [ADDR_W-1:0] addr;
        logic              in_range;
        logic              ok;
        logic [2:0]        set_code;
        logic [7:0]        blue;
        logic [7:0]        green;
        logic [7:0]        red;
        logic [7:0]        alpha;
        logic [7:0]        height;
        logic [7:0]        bush;
    } item_t;

    typedef struct packed {
        logic       written;
        logic [2:0] source_set;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] alpha;
        logic [7:0] height;
        logic [7:0] bush;
    } res_t;

endpackage

`default_nettype wire

// ----- src/tlac_ram.sv -----
`default_nettype none

module tlac_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- src/tlac_decode.sv -----
`default_nettype none

module tlac_decode (
    input  wire logic          operation,
    input  wire logic [5:0]    atlas_cell,
    input  wire logic [1:0]    layer,
    input  wire logic [4:0]    pixel_row,
    input  wire logic [4:0]    pixel_col,
    input  wire logic [10:0]   tile_value,
    input  wire logic [7:0]    src_blue,
    input  wire logic [7:0]    src_green,
    input  wire logic [7:0]    src_red,
    input  wire logic [7:0]    src_alpha,
    input  wire logic [7:0]    src_height,
    input  wire logic [7:0]    bush_layer,
    input  wire logic [2:0]    autotile_sets,
    input  wire logic [2:0]    autoheight_sets,
    output tlac_pkg::item_t    item
);

    import tlac_pkg::*;

    logic       is_main;
    logic [4:0] tv_hi;
    logic [8:0] tv_mul;
    logic [2:0] set_code;
    logic [2:0] set_idx;
    logic       set_ok;

    // tile_value / 48 == (tile_value >> 4) / 3, exact for values below 384
    assign is_main  = (tile_value >= MAIN_BASE);
    assign tv_hi    = tile_value[8:4];
    assign tv_mul   = 9'(tv_hi) * 9'd11;
    assign set_code = is_main ? 3'd0 : tv_mul[7:5];
    assign set_idx  = set_code - 3'd1;

    always_comb
    begin
        set_ok = 1'b1;
        if (!is_main)
        begin
            if (set_code == 3'd0)
            begin
                set_ok = 1'b0;
            end
            else
            begin
                if (set_idx >= autotile_sets)
                begin
                    set_ok = 1'b0;
                end
                if (op_t'(operation) == OP_DRAW && set_idx >= autoheight_sets)
                begin
                    set_ok = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        item.op       = op_t'(operation);
        item.layer    = layer;
        item.addr     = ADDR_W'({atlas_cell, pixel_row, pixel_col});
        item.in_range = (int'(atlas_cell) < ATLAS_TILES);
        item.ok       = item.in_range && set_ok && (int'(layer) < LAYERS);
        item.set_code = set_code;
        item.blue     = src_blue;
        item.green    = src_green;
        item.red      = src_red;
        item.alpha    = src_alpha;
        item.height   = src_height;
        item.bush     = bush_layer;
    end

endmodule

`default_nettype wire

// ----- src/tlac_merge.sv -----
`default_nettype none

module tlac_merge (
    input  wire tlac_pkg::item_t item,
    input  wire tlac_pkg::word_t old_word,
    output tlac_pkg::word_t      new_word,
    output logic                 we,
    output tlac_pkg::res_t       res
);

    import tlac_pkg::*;

    logic [7:0] layer_height;

    always_comb
    begin
        new_word = old_word;
        we       = 1'b0;
        if (item.ok)
        begin
            unique case (item.op)
                OP_DRAW:
                begin
                    for (int l = 0; l < LAYERS; l++)
                    begin
                        if (item.layer == 2'(l))
                        begin
                            new_word[HEIGHT_BYTE + l] = item.height;
                        end
                    end
                    new_word[BUSH_BYTE] = item.bush;
                    we = 1'b1;
                    // colour only lands on a still transparent atlas pixel
                    if (old_word[3] == 8'd0 && item.alpha != 8'd0)
                    begin
                        new_word[0] = item.blue;
                        new_word[1] = item.green;
                        new_word[2] = item.red;
                        new_word[3] = ALPHA_OPAQUE;
                    end
                end
                OP_REFRESH:
                begin
                    if (item.alpha != 8'd0)
                    begin
                        new_word[0] = item.blue;
                        new_word[1] = item.green;
                        new_word[2] = item.red;
                        new_word[3] = item.alpha;
                        we = 1'b1;
                    end
                end
                default:
                begin
                    we = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        layer_height = 8'd0;
        for (int l = 0; l < LAYERS; l++)
        begin
            if (item.layer == 2'(l))
            begin
                layer_height = new_word[HEIGHT_BYTE + l];
            end
        end
    end

    always_comb
    begin
        res.written    = we;
        res.source_set = item.set_code;
        if (item.in_range)
        begin
            res.blue   = new_word[0];
            res.green  = new_word[1];
            res.red    = new_word[2];
            res.alpha  = new_word[3];
            res.height = layer_height;
            res.bush   = new_word[BUSH_BYTE];
        end
        else
        begin
            res.blue   = 8'd0;
            res.green  = 8'd0;
            res.red    = 8'd0;
            res.alpha  = 8'd0;
            res.height = 8'd0;
            res.bush   = 8'd0;
        end
    end

endmodule

`default_nettype wire

// ----- src/tile_layer_atlas_compositor_top.sv -----
// Pipeline: the atlas is read at the input transfer edge as the item enters
// stage 1; the merge result goes into the output register when stage 1 advances.
// Throughput: one item per cycle unless clearing or stalled by out_ready; the
// atlas read-modify-write loop forwards the last written word, so back-to-back
// hits on the same pixel do not stall. Reset: the set counts return to 7 at once;
// a clearing pass then zeroes the STORE_DEPTH (65536) words one per cycle, with in_ready low.
`default_nettype none

module tile_layer_atlas_compositor_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        operation,
    input  wire logic [5:0]  atlas_cell,
    input  wire logic [1:0]  layer,
    input  wire logic [4:0]  pixel_row,
    input  wire logic [4:0]  pixel_col,
    input  wire logic [10:0] tile_value,
    input  wire logic [7:0]  src_blue,
    input  wire logic [7:0]  src_green,
    input  wire logic [7:0]  src_red,
    input  wire logic [7:0]  src_alpha,
    input  wire logic [7:0]  src_height,
    input  wire logic [7:0]  bush_layer,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             written,
    output logic      [2:0]  source_set,
    output logic      [7:0]  out_blue,
    output logic      [7:0]  out_green,
    output logic      [7:0]  out_red,
    output logic      [7:0]  out_alpha,
    output logic      [7:0]  out_height,
    output logic      [7:0]  out_bush
);

    import tlac_pkg::*;

    logic [2:0]        autotile_sets_reg;
    logic [2:0]        autoheight_sets_reg;
    logic              clear_active_reg;
    logic [ADDR_W-1:0] clear_cnt_reg;
    logic              s1_valid_reg;
    item_t             s1_reg;
    logic              fwd_valid_reg;
    logic [ADDR_W-1:0] fwd_addr_reg;
    word_t             fwd_word_reg;
    logic              out_valid_reg;
    res_t              out_reg;

    item_t             dec_item;
    word_t             ram_rdata;
    word_t             old_word;
    word_t             new_word;
    logic              merge_we;
    res_t              merge_res;
    logic              s1_adv;
    logic              in_xfer;
    logic              cfg_wr;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    word_t             ram_wdata;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[2])
            REG_AUTOTILE:   prdata = {29'd0, autotile_sets_reg};
            REG_AUTOHEIGHT: prdata = {29'd0, autoheight_sets_reg};
            default:        prdata = 32'd0;
        endcase
    end

    tlac_decode u_decode (
        .operation       (operation),
        .atlas_cell      (atlas_cell),
        .layer           (layer),
        .pixel_row       (pixel_row),
        .pixel_col       (pixel_col),
        .tile_value      (tile_value),
        .src_blue        (src_blue),
        .src_green       (src_green),
        .src_red         (src_red),
        .src_alpha       (src_alpha),
        .src_height      (src_height),
        .bush_layer      (bush_layer),
        .autotile_sets   (autotile_sets_reg),
        .autoheight_sets (autoheight_sets_reg),
        .item            (dec_item)
    );

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !clear_active_reg && (!s1_valid_reg || s1_adv);
    assign in_xfer  = in_valid && in_ready;

    // the word written on the same edge as this item's read is not in ram_rdata
    assign old_word = (fwd_valid_reg && fwd_addr_reg == s1_reg.addr) ? fwd_word_reg
                                                                     : ram_rdata;

    tlac_merge u_merge (
        .item     (s1_reg),
        .old_word (old_word),
        .new_word (new_word),
        .we       (merge_we),
        .res      (merge_res)
    );

    assign ram_we    = clear_active_reg || (s1_adv && merge_we);
    assign ram_waddr = clear_active_reg ? clear_cnt_reg : s1_reg.addr;
    assign ram_wdata = clear_active_reg ? word_t'('0) : new_word;

    tlac_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_DEPTH)
    ) u_atlas (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_xfer),
        .raddr (dec_item.addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            autotile_sets_reg   <= 3'd7;
            autoheight_sets_reg <= 3'd7;
            clear_active_reg    <= 1'b1;
            clear_cnt_reg       <= '0;
            s1_valid_reg        <= 1'b0;
            fwd_valid_reg       <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (paddr[2])
                    REG_AUTOTILE:   autotile_sets_reg   <= pwdata[2:0];
                    REG_AUTOHEIGHT: autoheight_sets_reg <= pwdata[2:0];
                    default:        autotile_sets_reg   <= autotile_sets_reg;
                endcase
            end

            if (clear_active_reg)
            begin
                clear_cnt_reg <= clear_cnt_reg + 1'b1;
                if (clear_cnt_reg == ADDR_W'(STORE_DEPTH - 1))
                begin
                    clear_active_reg <= 1'b0;
                end
            end

            if (in_xfer)
            begin
                s1_valid_reg <= 1'b1;
                s1_reg       <= dec_item;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv && merge_we)
            begin
                fwd_valid_reg <= 1'b1;
                fwd_addr_reg  <= s1_reg.addr;
                fwd_word_reg  <= new_word;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
                out_reg       <= merge_res;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign written    = out_reg.written;
    assign source_set = out_reg.source_set;
    assign out_blue   = out_reg.blue;
    assign out_green  = out_reg.green;
    assign out_red    = out_reg.red;
    assign out_alpha  = out_reg.alpha;
    assign out_height = out_reg.height;
    assign out_bush   = out_reg.bush;

    a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clear_active_reg |-> !in_ready && !s1_valid_reg)
        else $error("item taken during atlas clear");

    a_ram_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> clear_active_reg || s1_adv)
        else $error("atlas write without a retiring item");

    a_draw_sets_bush: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_reg.ok && s1_reg.op == OP_DRAW)
            |=> out_valid && written && out_bush == $past(s1_reg.bush))
        else $error("draw result lost its bush byte");

    a_fwd_tracks_write: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && merge_we) |=> fwd_valid_reg && fwd_word_reg == $past(ram_wdata))
        else $error("forward register out of step with atlas write");

    a_skip_not_written: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && !s1_reg.ok) |=> !written)
        else $error("skipped item reported as written");

endmodule

`default_nettype wire
